// ----- hw/rtl/lps_pkg.sv -----
package lps_pkg;

   // sizing
   localparam int MAX_LEN       = 64;
   localparam int ELEM_BITS     = 32;
   localparam int WORD_BITS     = 32;
   localparam int IDX_BITS      = $clog2(MAX_LEN);
   localparam int CNT_BITS      = $clog2(MAX_LEN + 1);
   localparam int CSR_IDX_BITS  = 4;
   localparam int CSR_DATA_BITS = 1;

   // register map
   localparam logic [CSR_IDX_BITS-1:0] CSR_DIRECTION    = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_SIGNED_ORDER = CSR_IDX_BITS'(1);

   typedef logic [ELEM_BITS-1:0] elem_type;
   typedef logic [IDX_BITS-1:0]  idx_type;
   typedef logic [CNT_BITS-1:0]  cnt_type;
   typedef logic [IDX_BITS:0]    ext_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PIV_PRIME,
      ST_PIV_FILL,
      ST_PIV_SCAN,
      ST_MATE_PRIME,
      ST_MATE_SCAN,
      ST_SWAP_P,
      ST_SWAP_M,
      ST_REV_A,
      ST_REV_B,
      ST_REV_C,
      ST_REV_D,
      ST_EMIT_PRIME,
      ST_EMIT
   } state_type;

   // element ram read address source
   typedef enum logic [3:0] {
      RD_TOP,
      RD_SCAN_DEC,
      RD_LO,
      RD_HI,
      RD_LO_NEXT,
      RD_HI_NEXT,
      RD_ZERO,
      RD_EMIT,
      RD_EMIT_NEXT
   } rd_sel_type;

   // element ram write source
   typedef enum logic [2:0] {
      WR_NONE,
      WR_LOAD,
      WR_PIV,
      WR_MATE,
      WR_LO,
      WR_HI
   } wr_sel_type;

   typedef struct packed {
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
      logic       prev_load;
      logic       pivot_take;
      logic       wrap_take;
      logic       mate_take;
      logic       tmp_load;
      logic       rev_step;
      logic       emit_start;
      logic       emit_load;
      logic       seq_clear;
   } cmd_type;

   typedef struct packed {
      logic single;
      logic piv_hit;
      logic mate_hit;
      logic scan_zero;
      logic rev_any;
      logic rev_more;
      logic out_free;
      logic emit_done;
   } stat_type;

   // true if a comes before b in the selected order and direction
   function automatic logic lps_before(elem_type a, elem_type b, logic dir, logic sgn);
      elem_type flip;
      elem_type ka;
      elem_type kb;
      flip = elem_type'(sgn) << (ELEM_BITS - 1);
      ka   = a ^ flip;
      kb   = b ^ flip;
      return dir ? (ka > kb) : (ka < kb);
   endfunction

endpackage

// ----- hw/rtl/lps_req_if.sv -----
interface lps_req_if
   import lps_pkg::*;
   ;
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] element;
   logic                 last_in;

   modport source (output valid, output element, output last_in, input ready);
   modport sink (input valid, input element, input last_in, output ready);
endinterface

// ----- hw/rtl/lps_rsp_if.sv -----
interface lps_rsp_if
   import lps_pkg::*;
   ;
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] element_out;
   logic                 last_out;
   logic                 advanced;
   logic                 overflow;

   modport source (output valid, output element_out, output last_out, output advanced,
                   output overflow, input ready);
   modport sink (input valid, input element_out, input last_out, input advanced,
                 input overflow, output ready);
endinterface

// ----- hw/rtl/lps_ram.sv -----
module lps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/lps_ctrl.sv -----
module lps_ctrl
   import lps_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_last_in,
   output logic     req_ready,
   output cmd_type  cmd,
   input  stat_type stat
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and datapath commands
   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      cmd.rd_sel = RD_ZERO;
      cmd.wr_sel = WR_NONE;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.wr_sel = WR_LOAD;
               if (req_last_in) begin
                  state_in = ST_PIV_PRIME;
               end
            end
         end
         // start pivot scan from the end, or go straight to emit for a single element
         ST_PIV_PRIME: begin
            if (stat.single) begin
               cmd.wrap_take = 1'b1;
               state_in      = ST_EMIT_PRIME;
            end else begin
               cmd.rd_sel = RD_TOP;
               state_in   = ST_PIV_FILL;
            end
         end
         ST_PIV_FILL: begin
            cmd.rd_sel    = RD_SCAN_DEC;
            cmd.prev_load = 1'b1;
            state_in      = ST_PIV_SCAN;
         end
         ST_PIV_SCAN: begin
            if (stat.piv_hit) begin
               cmd.pivot_take = 1'b1;
               state_in       = ST_MATE_PRIME;
            end else if (stat.scan_zero) begin
               // no pivot: reverse the whole sequence
               cmd.wrap_take = 1'b1;
               state_in      = ST_REV_A;
            end else begin
               cmd.rd_sel    = RD_SCAN_DEC;
               cmd.prev_load = 1'b1;
            end
         end
         // rightmost mate, always found before the pivot
         ST_MATE_PRIME: begin
            cmd.rd_sel = RD_TOP;
            state_in   = ST_MATE_SCAN;
         end
         ST_MATE_SCAN: begin
            if (stat.mate_hit) begin
               cmd.mate_take = 1'b1;
               state_in      = ST_SWAP_P;
            end else begin
               cmd.rd_sel = RD_SCAN_DEC;
            end
         end
         ST_SWAP_P: begin
            cmd.wr_sel = WR_PIV;
            state_in   = ST_SWAP_M;
         end
         ST_SWAP_M: begin
            cmd.wr_sel = WR_MATE;
            state_in   = stat.rev_any ? ST_REV_A : ST_EMIT_PRIME;
         end
         // suffix reversal, one swapped pair per pass through ST_REV_C and ST_REV_D
         ST_REV_A: begin
            cmd.rd_sel = RD_LO;
            state_in   = ST_REV_B;
         end
         ST_REV_B: begin
            cmd.rd_sel   = RD_HI;
            cmd.tmp_load = 1'b1;
            state_in     = ST_REV_C;
         end
         ST_REV_C: begin
            cmd.wr_sel = WR_LO;
            cmd.rd_sel = RD_LO_NEXT;
            state_in   = ST_REV_D;
         end
         ST_REV_D: begin
            cmd.wr_sel   = WR_HI;
            cmd.rd_sel   = RD_HI_NEXT;
            cmd.tmp_load = 1'b1;
            cmd.rev_step = 1'b1;
            state_in     = stat.rev_more ? ST_REV_C : ST_EMIT_PRIME;
         end
         // stream the sequence out
         ST_EMIT_PRIME: begin
            cmd.rd_sel     = RD_ZERO;
            cmd.emit_start = 1'b1;
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.emit_done) begin
               cmd.seq_clear = 1'b1;
               state_in      = ST_IDLE;
            end else if (stat.out_free) begin
               cmd.emit_load = 1'b1;
               cmd.rd_sel    = RD_EMIT_NEXT;
            end else begin
               cmd.rd_sel = RD_EMIT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/lps_dp.sv -----
module lps_dp
   import lps_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  logic [WORD_BITS-1:0]     req_element,
   input  logic                     rsp_ready,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   output logic                     rsp_valid,
   output logic [WORD_BITS-1:0]     rsp_element_out,
   output logic                     rsp_last_out,
   output logic                     rsp_advanced,
   output logic                     rsp_overflow
);

   // control registers
   cnt_type  count_ff;
   logic     ovf_ff;
   logic     dir_ff;
   logic     sgn_ff;
   logic     out_valid_ff;

   // payload registers
   idx_type  scan_ff;
   idx_type  piv_ff;
   idx_type  mate_ff;
   idx_type  lo_ff;
   idx_type  hi_ff;
   cnt_type  emit_ff;
   elem_type prev_ff;
   elem_type piv_val_ff;
   elem_type mate_val_ff;
   elem_type tmp_ff;
   logic     adv_ff;
   elem_type out_elem_ff;
   logic     out_last_ff;
   logic     out_adv_ff;
   logic     out_ovf_ff;

   // ram ports
   logic     wr_en;
   idx_type  wr_addr;
   elem_type wr_data;
   idx_type  rd_addr;
   elem_type rd_data;

   logic     room;
   idx_type  top_idx;
   logic     out_free;

   assign room     = count_ff < cnt_type'(MAX_LEN);
   assign top_idx  = idx_type'(count_ff - cnt_type'(1));
   assign out_free = !out_valid_ff || rsp_ready;

   lps_ram #(
      .WIDTH(ELEM_BITS),
      .DEPTH(MAX_LEN)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // write port select
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = lo_ff;
      wr_data = rd_data;
      case (cmd.wr_sel)
         WR_LOAD: begin
            wr_en   = room;
            wr_addr = idx_type'(count_ff);
            wr_data = elem_type'(req_element);
         end
         WR_PIV: begin
            wr_en   = 1'b1;
            wr_addr = piv_ff;
            wr_data = mate_val_ff;
         end
         WR_MATE: begin
            wr_en   = 1'b1;
            wr_addr = mate_ff;
            wr_data = piv_val_ff;
         end
         WR_LO: begin
            wr_en   = 1'b1;
            wr_addr = lo_ff;
            wr_data = rd_data;
         end
         WR_HI: begin
            wr_en   = 1'b1;
            wr_addr = hi_ff;
            wr_data = tmp_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // read port select
   always_comb begin
      case (cmd.rd_sel)
         RD_TOP:       rd_addr = top_idx;
         RD_SCAN_DEC:  rd_addr = scan_ff - idx_type'(1);
         RD_LO:        rd_addr = lo_ff;
         RD_HI:        rd_addr = hi_ff;
         RD_LO_NEXT:   rd_addr = lo_ff + idx_type'(1);
         RD_HI_NEXT:   rd_addr = hi_ff - idx_type'(1);
         RD_EMIT:      rd_addr = idx_type'(emit_ff);
         RD_EMIT_NEXT: rd_addr = idx_type'(emit_ff + cnt_type'(1));
         default:      rd_addr = '0;
      endcase
   end

   // status to the controller
   always_comb begin
      stat.single    = count_ff == cnt_type'(1);
      stat.piv_hit   = lps_before(rd_data, prev_ff, dir_ff, sgn_ff);
      stat.mate_hit  = lps_before(piv_val_ff, rd_data, dir_ff, sgn_ff);
      stat.scan_zero = scan_ff == '0;
      stat.rev_any   = lo_ff < hi_ff;
      stat.rev_more  = (ext_type'(lo_ff) + ext_type'(2)) < ext_type'(hi_ff);
      stat.out_free  = out_free;
      stat.emit_done = emit_ff == count_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         dir_ff       <= 1'b0;
         sgn_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == CSR_DIRECTION) begin
            dir_ff <= csr_wdata[0];
         end
         if (csr_we && csr_index == CSR_SIGNED_ORDER) begin
            sgn_ff <= csr_wdata[0];
         end
         if (cmd.seq_clear) begin
            count_ff <= '0;
            ovf_ff   <= 1'b0;
         end else if (cmd.wr_sel == WR_LOAD) begin
            if (room) begin
               count_ff <= count_ff + cnt_type'(1);
            end else begin
               ovf_ff <= 1'b1;
            end
         end
         if (cmd.emit_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // scan, pivot, mate, reversal and emit bookkeeping
   always_ff @(posedge clock) begin
      if (cmd.rd_sel == RD_TOP) begin
         scan_ff <= top_idx;
      end else if (cmd.rd_sel == RD_SCAN_DEC) begin
         scan_ff <= scan_ff - idx_type'(1);
      end
      if (cmd.prev_load) begin
         prev_ff <= rd_data;
      end
      if (cmd.tmp_load) begin
         tmp_ff <= rd_data;
      end
      if (cmd.pivot_take) begin
         piv_ff     <= scan_ff;
         piv_val_ff <= rd_data;
         lo_ff      <= scan_ff + idx_type'(1);
         hi_ff      <= top_idx;
         adv_ff     <= 1'b1;
      end else if (cmd.wrap_take) begin
         lo_ff  <= '0;
         hi_ff  <= top_idx;
         adv_ff <= 1'b0;
      end else if (cmd.rev_step) begin
         lo_ff <= lo_ff + idx_type'(1);
         hi_ff <= hi_ff - idx_type'(1);
      end
      if (cmd.mate_take) begin
         mate_ff     <= scan_ff;
         mate_val_ff <= rd_data;
      end
      if (cmd.emit_start) begin
         emit_ff <= '0;
      end else if (cmd.emit_load) begin
         emit_ff <= emit_ff + cnt_type'(1);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         out_elem_ff <= rd_data;
         out_last_ff <= (emit_ff + cnt_type'(1)) == count_ff;
         out_adv_ff  <= adv_ff;
         out_ovf_ff  <= ovf_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_element_out = WORD_BITS'(out_elem_ff);
   assign rsp_last_out    = out_last_ff;
   assign rsp_advanced    = out_adv_ff;
   assign rsp_overflow    = out_ovf_ff;

endmodule

// ----- hw/rtl/lexicographic_permutation_step.sv -----
// channel   dir  handshake      payload
// req_chan  in   valid/ready    element, last_in
// rsp_chan  out  valid/ready    element_out, last_out, advanced, overflow
// csr       in   csr_we         csr_index, csr_wdata
//
// a sequence of n elements loads at one element per cycle; after the last one the
// pivot scan, mate scan, swap and reversal run, then the emit pass, all paced by the
// single read port of the element ram.
// reset is synchronous; no clearing pass, only element ram data below the count is used.
// input is taken only while loading; the output register drains independently, and a
// stalled rsp_chan holds the emit pass.
module lexicographic_permutation_step
   import lps_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   lps_req_if.sink                  req_chan,
   lps_rsp_if.source                rsp_chan,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   lps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_last_in(req_chan.last_in),
      .req_ready  (req_chan.ready),
      .cmd        (cmd),
      .stat       (stat)
   );

   // element store, compare and output register
   lps_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_element    (req_chan.element),
      .rsp_ready      (rsp_chan.ready),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_valid      (rsp_chan.valid),
      .rsp_element_out(rsp_chan.element_out),
      .rsp_last_out   (rsp_chan.last_out),
      .rsp_advanced   (rsp_chan.advanced),
      .rsp_overflow   (rsp_chan.overflow)
   );

endmodule
